// ----- hdl/dtpb_pkg.sv -----
// ----------------------------------------------------------------------------
// dtpb_pkg
// Shared types, constants and arithmetic helpers for the depth-to-point
// back-projection block.
// ----------------------------------------------------------------------------
package dtpb_pkg;

  localparam int CoordBits  = 12;
  localparam int SampleBits = 16;
  // offset magnitude covers both (count << 16) and the Q12.16 center
  localparam int MagW       = (CoordBits + 16 > 28) ? CoordBits + 16 : 28;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [15:0] SampleMask = 16'((32'd1 << SampleBits) - 32'd1);

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_SCALE    = 3'd2,
    REG_RECIP_X  = 3'd3,
    REG_RECIP_Y  = 3'd4,
    REG_CENTER_X = 3'd5,
    REG_CENTER_Y = 3'd6
  } dtpb_reg_e;

  localparam logic [12:0] RstWidth   = 13'd512;
  localparam logic [12:0] RstHeight  = 13'd424;
  localparam logic [31:0] RstScale   = 32'd16777;
  localparam logic [31:0] RstRecipX  = 32'd7227960;
  localparam logic [31:0] RstRecipY  = 32'd7266760;
  localparam logic [27:0] RstCenterX = 28'd22236876;
  localparam logic [27:0] RstCenterY = 28'd15908150;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [31:0] depth_scale;
    logic [31:0] recip_focal_x;
    logic [31:0] recip_focal_y;
    logic [27:0] center_x;
    logic [27:0] center_y;
  } dtpb_cfg_t;

  // one classified pixel waiting for the arithmetic
  typedef struct packed {
    logic [15:0]     sample;
    logic [MagW-1:0] mag_x;
    logic            neg_x;
    logic [MagW-1:0] mag_y;
    logic            neg_y;
    logic            last;
  } dtpb_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Z,
    ST_XM,
    ST_XL,
    ST_XH,
    ST_XS,
    ST_YL,
    ST_YH,
    ST_YS
  } dtpb_state_e;

  // last position for a size register; zero acts as one, large values clamp
  function automatic logic [CoordBits-1:0] size_m1(input logic [12:0] v);
    logic [16:0] top;
    top = 17'(32'd1 << CoordBits);
    if (v == 13'd0) begin
      return '0;
    end else if (17'(v) > top) begin
      return '1;
    end
    return CoordBits'(13'(v - 13'd1));
  endfunction

  // Q8.24 * raw -> Q16.16, round half up, saturate to 31 bits
  function automatic logic [30:0] sat_depth(input logic [63:0] prod);
    logic [63:0] t;
    t = prod + 64'd128;
    if (t[63:39] != '0) begin
      return 31'h7FFF_FFFF;
    end
    return t[38:8];
  endfunction

  // hz = hi*z, a = lo*z + 2^47; finish rounding, apply sign, saturate
  function automatic logic [31:0] lat_fin(input logic [63:0] hz,
                                          input logic [63:0] a,
                                          input logic        neg);
    logic [63:0] sum;
    logic [47:0] res;
    logic [47:0] nres;
    sum  = hz + {32'd0, a[63:32]};
    res  = sum[63:16];
    nres = 48'd0 - res;
    if (neg) begin
      if (res >= 48'h0000_8000_0000) begin
        return 32'h8000_0000;
      end
      return nres[31:0];
    end
    if (res > 48'h0000_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return res[31:0];
  endfunction

endpackage

// ----- hdl/dtpb_front.sv -----
// ----------------------------------------------------------------------------
// dtpb_front
// Accepts depth samples, tracks column and row, and classifies each pixel
// into signed offsets from the principal point plus an end-of-frame flag.
// ----------------------------------------------------------------------------
module dtpb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtpb_pkg::dtpb_cfg_t  cfg_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,   // [15:0] depth_sample
  input  logic                 full_i,
  output logic                 push_o,
  output dtpb_pkg::dtpb_item_t item_o
);

  logic [dtpb_pkg::CoordBits-1:0] col_q, col_d;
  logic [dtpb_pkg::CoordBits-1:0] row_q, row_d;
  logic [dtpb_pkg::CoordBits-1:0] col_last, row_last;
  logic                           col_end, row_end;
  logic [dtpb_pkg::MagW-1:0]      pos_x, pos_y, ctr_x, ctr_y;
  logic                           below_x, below_y;

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

  assign col_last = dtpb_pkg::size_m1(cfg_i.image_width);
  assign row_last = dtpb_pkg::size_m1(cfg_i.image_height);
  // a counter past the bound (size shrunk mid-frame) counts as the end
  assign col_end  = col_q >= col_last;
  assign row_end  = row_q >= row_last;

  assign pos_x   = dtpb_pkg::MagW'({col_q, 16'd0});
  assign pos_y   = dtpb_pkg::MagW'({row_q, 16'd0});
  assign ctr_x   = dtpb_pkg::MagW'(cfg_i.center_x);
  assign ctr_y   = dtpb_pkg::MagW'(cfg_i.center_y);
  assign below_x = pos_x < ctr_x;
  assign below_y = pos_y < ctr_y;

  always_comb begin
    item_o.sample = s_axis_tdata_i & dtpb_pkg::SampleMask;
    item_o.mag_x  = below_x ? (ctr_x - pos_x) : (pos_x - ctr_x);
    item_o.neg_x  = below_x;
    item_o.mag_y  = below_y ? (ctr_y - pos_y) : (pos_y - ctr_y);
    item_o.neg_y  = !below_y;   // y points up
    item_o.last   = col_end && row_end;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- hdl/dtpb_queue.sv -----
// ----------------------------------------------------------------------------
// dtpb_queue
// Short register FIFO between the classifier and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module dtpb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dtpb_pkg::dtpb_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output dtpb_pkg::dtpb_item_t item_o,
  output logic                 empty_o
);

  localparam int Depth = dtpb_pkg::QueueDepth;
  localparam int PtrW  = dtpb_pkg::QPtrW;

  dtpb_pkg::dtpb_item_t mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]        cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- hdl/dtpb_back.sv -----
// ----------------------------------------------------------------------------
// dtpb_back
// Arithmetic sequencer: one shared 32x32 multiplier computes z, then the
// x and y lateral products in three passes each, into an output register.
// ----------------------------------------------------------------------------
module dtpb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtpb_pkg::dtpb_cfg_t  cfg_i,
  input  logic                 empty_i,
  input  dtpb_pkg::dtpb_item_t item_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [95:0]          m_axis_tdata_o,  // [31:0] point_x, [63:32] point_y,
                                                // [94:64] point_z, [95] zero pad
  output logic                 m_axis_tlast_o   // frame_last
);

  dtpb_pkg::dtpb_state_e state_q, state_d;
  dtpb_pkg::dtpb_item_t  item_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] product;
  logic [63:0] prod_q, a_q;
  logic [31:0] hi_q, x_q;
  logic [30:0] z_q;
  logic        load_out, out_free;

  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q;
  logic [30:0] out_z_q;
  logic        out_last_q;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign product  = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q) inside
      dtpb_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = dtpb_pkg::ST_Z;
        end
      end
      dtpb_pkg::ST_Z: begin
        mul_a   = 32'(item_q.sample);
        mul_b   = cfg_i.depth_scale;
        state_d = dtpb_pkg::ST_XM;
      end
      dtpb_pkg::ST_XM: begin
        mul_a   = 32'(item_q.mag_x);
        mul_b   = cfg_i.recip_focal_x;
        state_d = dtpb_pkg::ST_XL;
      end
      dtpb_pkg::ST_XL, dtpb_pkg::ST_YL: begin
        mul_a   = prod_q[31:0];
        mul_b   = 32'(z_q);
        state_d = (state_q == dtpb_pkg::ST_XL) ? dtpb_pkg::ST_XH : dtpb_pkg::ST_YH;
      end
      dtpb_pkg::ST_XH, dtpb_pkg::ST_YH: begin
        mul_a   = hi_q;
        mul_b   = 32'(z_q);
        state_d = (state_q == dtpb_pkg::ST_XH) ? dtpb_pkg::ST_XS : dtpb_pkg::ST_YS;
      end
      dtpb_pkg::ST_XS: begin
        mul_a   = 32'(item_q.mag_y);
        mul_b   = cfg_i.recip_focal_y;
        state_d = dtpb_pkg::ST_YL;
      end
      dtpb_pkg::ST_YS: begin
        // hold here until the output register frees up
        if (out_free) begin
          load_out = 1'b1;
          if (!empty_i) begin
            pop_o   = 1'b1;
            state_d = dtpb_pkg::ST_Z;
          end else begin
            state_d = dtpb_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = dtpb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtpb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    if (state_q != dtpb_pkg::ST_YS) begin
      prod_q <= product;
    end
    if (state_q == dtpb_pkg::ST_XM) begin
      z_q <= dtpb_pkg::sat_depth(prod_q);
    end
    if (state_q == dtpb_pkg::ST_XL || state_q == dtpb_pkg::ST_YL) begin
      hi_q <= prod_q[63:32];
    end
    if (state_q == dtpb_pkg::ST_XH || state_q == dtpb_pkg::ST_YH) begin
      a_q <= prod_q + 64'h0000_8000_0000_0000;
    end
    if (state_q == dtpb_pkg::ST_XS) begin
      x_q <= dtpb_pkg::lat_fin(prod_q, a_q, item_q.neg_x);
    end
    if (load_out) begin
      out_x_q    <= x_q;
      out_y_q    <= dtpb_pkg::lat_fin(prod_q, a_q, item_q.neg_y);
      out_z_q    <= z_q;
      out_last_q <= item_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_z_q, out_y_q, out_x_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- hdl/depth_to_point_backprojection.sv -----
// ----------------------------------------------------------------------------
// depth_to_point_backprojection
// Raster depth stream in, pinhole back-projected Q16.16 points out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  s_axis    in   tvalid / tready   tdata[15:0] depth_sample
//  m_axis    out  tvalid / tready   tdata x,y,z ; tlast frame_last
//  cfg       in   cfg_we_i          cfg_idx_i, cfg_wdata_i
//
//  The back end works on one pixel at a time: one shared 32x32 multiplier
//  runs seven products per pixel in the back-end sequencer.
//  Input side has a 2-entry queue, so it takes samples while the back end
//  works and while a finished point waits in the output register.
//  Async reset clears counters and queue and loads register defaults.
// ----------------------------------------------------------------------------
module depth_to_point_backprojection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] depth_sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // [31:0] point_x, [63:32] point_y,
                                        // [94:64] point_z, [95] zero pad
  output logic        m_axis_tlast_o    // frame_last
);

  dtpb_pkg::dtpb_cfg_t  cfg_q;
  dtpb_pkg::dtpb_item_t front_item, queue_item;
  logic                 push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= dtpb_pkg::RstWidth;
      cfg_q.image_height  <= dtpb_pkg::RstHeight;
      cfg_q.depth_scale   <= dtpb_pkg::RstScale;
      cfg_q.recip_focal_x <= dtpb_pkg::RstRecipX;
      cfg_q.recip_focal_y <= dtpb_pkg::RstRecipY;
      cfg_q.center_x      <= dtpb_pkg::RstCenterX;
      cfg_q.center_y      <= dtpb_pkg::RstCenterY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtpb_pkg::REG_WIDTH:    cfg_q.image_width   <= cfg_wdata_i[12:0];
        dtpb_pkg::REG_HEIGHT:   cfg_q.image_height  <= cfg_wdata_i[12:0];
        dtpb_pkg::REG_SCALE:    cfg_q.depth_scale   <= cfg_wdata_i;
        dtpb_pkg::REG_RECIP_X:  cfg_q.recip_focal_x <= cfg_wdata_i;
        dtpb_pkg::REG_RECIP_Y:  cfg_q.recip_focal_y <= cfg_wdata_i;
        dtpb_pkg::REG_CENTER_X: cfg_q.center_x      <= cfg_wdata_i[27:0];
        dtpb_pkg::REG_CENTER_Y: cfg_q.center_y      <= cfg_wdata_i[27:0];
        default: ;
      endcase
    end
  end

  dtpb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (front_item)
  );

  dtpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  dtpb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .item_i          (queue_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- hdl/dtpb_checker.sv -----
// ----------------------------------------------------------------------------
// dtpb_checker
// Port-level checks on the back-projection block, bound to the top level.
// ----------------------------------------------------------------------------
module dtpb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // zero depth gives a zero point
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[94:64] == 31'd0) |->
      (m_axis_tdata_o[63:0] == 64'd0))
    else $error("nonzero lateral coordinate at zero depth");

  // output valid rises only from low; this check does not look at the input
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(m_axis_tvalid_o))
    else $error("output valid rose unexpectedly");

endmodule

bind depth_to_point_backprojection dtpb_checker u_dtpb_checker (.*);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for depth_to_point_backprojection. Random depth
// samples go in on the slave stream under several register settings; an
// in-bench projection model tracks the column and row counters and predicts
// every point, which is checked field by field at the master stream.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [30:0] pz;
    logic        last;
  } expected_point_t;

  // projection model plus queue of points still owed by the block
  class backproj_tracker;
    dtpb_pkg::dtpb_cfg_t            regs;
    logic [dtpb_pkg::CoordBits-1:0] col;
    logic [dtpb_pkg::CoordBits-1:0] row;
    expected_point_t                points[$];
    int                             errors;

    function new();
      regs.image_width   = dtpb_pkg::RstWidth;
      regs.image_height  = dtpb_pkg::RstHeight;
      regs.depth_scale   = dtpb_pkg::RstScale;
      regs.recip_focal_x = dtpb_pkg::RstRecipX;
      regs.recip_focal_y = dtpb_pkg::RstRecipY;
      regs.center_x      = dtpb_pkg::RstCenterX;
      regs.center_y      = dtpb_pkg::RstCenterY;
      col    = '0;
      row    = '0;
      errors = 0;
    endfunction

    function void write_reg(dtpb_pkg::dtpb_reg_e idx, logic [31:0] v);
      case (idx)
        dtpb_pkg::REG_WIDTH:    regs.image_width   = v[12:0];
        dtpb_pkg::REG_HEIGHT:   regs.image_height  = v[12:0];
        dtpb_pkg::REG_SCALE:    regs.depth_scale   = v;
        dtpb_pkg::REG_RECIP_X:  regs.recip_focal_x = v;
        dtpb_pkg::REG_RECIP_Y:  regs.recip_focal_y = v;
        dtpb_pkg::REG_CENTER_X: regs.center_x      = v[27:0];
        dtpb_pkg::REG_CENTER_Y: regs.center_y      = v[27:0];
        default: ;
      endcase
    endfunction

    function int clamp_extent(logic [12:0] v);
      if (v == 13'd0) return 1;
      if (int'(v) > (1 << dtpb_pkg::CoordBits)) return 1 << dtpb_pkg::CoordBits;
      return int'(v);
    endfunction

    // signed Q16.16 lateral offset: |count - center| * recip * z, rounded
    // half away from zero, then saturated
    function logic [31:0] lateral(logic [dtpb_pkg::CoordBits-1:0] cnt, logic [27:0] ctr,
                                  bit flip, logic [31:0] recip, logic [30:0] z);
      logic [63:0]  pos;
      logic [63:0]  mag;
      logic [127:0] acc;
      logic [63:0]  q;
      bit           neg;
      pos = 64'(cnt) << 16;
      if (pos >= 64'(ctr)) begin
        mag = pos - 64'(ctr);
        neg = 1'b0;
      end else begin
        mag = 64'(ctr) - pos;
        neg = 1'b1;
      end
      if (flip) neg = !neg;
      if (mag == 64'd0) return '0;
      acc = 128'(mag) * 128'(recip) * 128'(z) + (128'd1 << 47);
      q   = 64'(acc >> 48);
      if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
      return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function expected_point_t project_pixel(logic [15:0] raw);
      expected_point_t p;
      logic [63:0]     t;
      logic [30:0]     z;
      int              w;
      int              h;
      bit              col_end;
      bit              row_end;
      t = (64'(raw & dtpb_pkg::SampleMask) * 64'(regs.depth_scale) + 64'd128) >> 8;
      z = (t > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : t[30:0];
      p.px = lateral(col, regs.center_x, 1'b0, regs.recip_focal_x, z);
      p.py = lateral(row, regs.center_y, 1'b1, regs.recip_focal_y, z);
      p.pz = z;
      w = clamp_extent(regs.image_width);
      h = clamp_extent(regs.image_height);
      // counters past the bound (size shrunk mid-frame) act as last position
      col_end = int'(col) >= w - 1;
      row_end = int'(row) >= h - 1;
      p.last  = col_end && row_end;
      if (col_end) begin
        col = '0;
        row = row_end ? '0 : row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
      return p;
    endfunction

    function void note_sample(logic [15:0] raw);
      expected_point_t p;
      p      = project_pixel(raw);
      points = {points, p};
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_point(logic [95:0] data, logic last);
      expected_point_t e;
      if (points.size() == 0) begin
        $display("%0t unexpected point: tdata %h tlast %b", $time, data, last);
        errors++;
        return;
      end
      e = points.pop_front();
      compare("point_x", e.px, data[31:0]);
      compare("point_y", e.py, data[63:32]);
      compare("point_z", {1'b0, e.pz}, {1'b0, data[94:64]});
      compare("pad", 32'd0, {31'd0, data[95]});
      compare("frame_last", {31'd0, e.last}, {31'd0, last});
    endfunction

    function int pending();
      return points.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_idx_i       = dtpb_pkg::REG_WIDTH;
  logic [31:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  backproj_tracker tracker;
  logic [15:0]     burst[$];
  int              ready_hold = 0;
  int              random_sent;
  int              n_items;
  bit              steady;

  depth_to_point_backprojection uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output backpressure: long ready stretches, short and long stalls
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 9)) inside
        [0:5]: begin
          m_axis_tready_i <= 1'b1;
          ready_hold      <= $urandom_range(0, 30);
        end
        [6:8]: begin
          m_axis_tready_i <= 1'b0;
          ready_hold      <= $urandom_range(0, 3);
        end
        default: begin
          m_axis_tready_i <= 1'b0;
          ready_hold      <= $urandom_range(8, 40);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_point(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  function automatic int pick_gap(bit no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [15:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 15) return 16'hFFFF;
    if (r < 25) return 16'($urandom_range(1, 255));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] rand_reg(dtpb_pkg::dtpb_reg_e idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (idx) inside
      dtpb_pkg::REG_WIDTH, dtpb_pkg::REG_HEIGHT: begin
        if (r < 70) return $urandom_range(1, 8);
        if (r < 85) return $urandom_range(9, 64);
        if (r < 90) return 32'd0;
        if (r < 95) return $urandom_range(4096, 8191);
        return $urandom_range(0, 8191);
      end
      dtpb_pkg::REG_SCALE: begin
        if (r < 60) return $urandom_range(1000, 32'd1 << 22);
        if (r < 85) return $urandom();
        if (r < 92) return 32'd0;
        return 32'hFFFF_FFFF;
      end
      dtpb_pkg::REG_RECIP_X, dtpb_pkg::REG_RECIP_Y: begin
        if (r < 60) return $urandom_range(32'd1 << 20, 32'd1 << 27);
        if (r < 85) return $urandom();
        if (r < 92) return 32'd0;
        return 32'hFFFF_FFFF;
      end
      default: begin
        if (r < 60) return $urandom_range(0, 32'd64 << 16);
        if (r < 85) return $urandom() & 32'h0FFF_FFFF;
        if (r < 92) return 32'd0;
        return 32'h0FFF_FFFF;
      end
    endcase
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_sample(input logic [15:0] v, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_sample(v);
  endtask

  task automatic play_burst(input bit no_idle);
    foreach (burst[i]) send_sample(burst[i], pick_gap(no_idle));
  endtask

  // drop valid and wait until every owed point has come out
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input dtpb_pkg::dtpb_reg_e idx, input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    tracker.write_reg(idx, v);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, sample extremes and bit patterns
    burst = {16'd0, 16'd1, 16'hFFFF, 16'd1000, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
    play_burst(1'b0);
    settle();

    // zero sizes (every pixel closes a frame), full-scale gains, x saturates low
    write_reg(dtpb_pkg::REG_WIDTH, 32'd0);
    write_reg(dtpb_pkg::REG_HEIGHT, 32'd0);
    write_reg(dtpb_pkg::REG_SCALE, 32'hFFFF_FFFF);
    write_reg(dtpb_pkg::REG_RECIP_X, 32'hFFFF_FFFF);
    write_reg(dtpb_pkg::REG_RECIP_Y, 32'hFFFF_FFFF);
    write_reg(dtpb_pkg::REG_CENTER_X, 32'h0FFF_FFFF);
    write_reg(dtpb_pkg::REG_CENTER_Y, 32'd0);
    end_writes();
    burst = {16'hFFFF, 16'd1, 16'd0, 16'd2};
    play_burst(1'b1);
    settle();

    // oversize clamps, unit scale so z saturates, x and y saturate high
    write_reg(dtpb_pkg::REG_WIDTH, 32'd8191);
    write_reg(dtpb_pkg::REG_HEIGHT, 32'd8191);
    write_reg(dtpb_pkg::REG_SCALE, 32'd1 << 24);
    write_reg(dtpb_pkg::REG_CENTER_X, 32'd0);
    write_reg(dtpb_pkg::REG_CENTER_Y, 32'h0FFF_FFFF);
    end_writes();
    burst = {16'hFFFF, 16'hFFFF, 16'd0, 16'd300, 16'd12};
    play_burst(1'b0);
    settle();

    // shrink below the running column; center on a pixel and on a half pixel
    write_reg(dtpb_pkg::REG_WIDTH, 32'd3);
    write_reg(dtpb_pkg::REG_HEIGHT, 32'd2);
    write_reg(dtpb_pkg::REG_SCALE, dtpb_pkg::RstScale);
    write_reg(dtpb_pkg::REG_RECIP_X, dtpb_pkg::RstRecipX);
    write_reg(dtpb_pkg::REG_RECIP_Y, dtpb_pkg::RstRecipY);
    write_reg(dtpb_pkg::REG_CENTER_X, 32'd1 << 16);
    write_reg(dtpb_pkg::REG_CENTER_Y, 32'h0000_8000);
    end_writes();
    burst = {16'd4000, 16'd65000, 16'd1, 16'd3, 16'd0, 16'd777, 16'd2048, 16'd9};
    play_burst(1'b0);

    random_sent = 0;
    while (random_sent < 1600) begin
      settle();
      for (int i = 0; i < 7; i++) begin
        if ($urandom_range(0, 1) == 1) begin
          write_reg(dtpb_pkg::dtpb_reg_e'(i), rand_reg(dtpb_pkg::dtpb_reg_e'(i)));
        end
      end
      end_writes();
      steady  = ($urandom_range(0, 4) == 0);
      n_items = $urandom_range(10, 120);
      repeat (n_items) send_sample(rand_sample(), pick_gap(steady));
      random_sent += n_items;
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
